>>> design/length_prefixed_message_ring_assert.svh
// Assertion macros shared by the message ring checkers
`ifndef LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define LPMR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("message ring check failed");

// Next-cycle implication, disabled while reset is asserted
`define LPMR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("message ring check failed");

`endif

>>> design/lpmr_pkg.sv
// Shared constants and codes for the length-prefixed message ring
package lpmr_pkg;

  localparam int unsigned DEF_BUFFER_BYTES   = 4096;
  localparam int unsigned DEF_RESERVED_SLOTS = 1;
  localparam int unsigned DEF_HEADER_BYTES   = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_CORRUPT  = 2'd3
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

endpackage

>>> design/length_prefixed_message_ring.sv
// Length-prefixed message ring: byte FIFO of whole messages with header check
// Steps: push continuation writes its byte; first push counts stored bytes, takes room
//   less header, admits or refuses, writes header and first byte; pop in a message reads
//   a byte, at a message start it checks fill and header first. A new word is taken once
//   the result enters the output register; one subtractor, one RAM access a cycle.
// Reset (rst_ni low, asynchronous): pointers, counters to zero; byte store not cleared.
module length_prefixed_message_ring #(
  parameter int unsigned BUFFER_BYTES   = lpmr_pkg::DEF_BUFFER_BYTES,
  parameter int unsigned RESERVED_SLOTS = lpmr_pkg::DEF_RESERVED_SLOTS,
  parameter int unsigned HEADER_BYTES   = lpmr_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [lpmr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          first_byte_i,
  input  logic [lpmr_pkg::LEN_W-1:0]    message_length_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lpmr_pkg::BYTE_W-1:0]   data_out_o,
  output logic                          last_byte_o,
  output logic [lpmr_pkg::LEN_W-1:0]    length_out_o,
  output logic [lpmr_pkg::STATUS_W-1:0] status_o
);

  import lpmr_pkg::*;

  // ring index width; every stored index stays below BUFFER_BYTES
  localparam int unsigned AW     = $clog2(BUFFER_BYTES);
  // widest unsigned quantity the subtractor sees, plus sign and headroom
  localparam int unsigned XW     = (AW > LEN_W) ? AW : LEN_W;
  localparam int unsigned DW     = XW + 2;
  localparam int unsigned HDR_W  = 8 * HEADER_BYTES;
  localparam int unsigned CW     = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  // room test: B - RESERVED - used >= len + HEADER  <=>  K - used - len >= 0
  localparam int unsigned ROOM_K = BUFFER_BYTES - RESERVED_SLOTS - HEADER_BYTES;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PBYTE  = 4'd1;   // push continuation byte
  localparam logic [3:0] S_PUSED  = 4'd2;   // first push: stored byte count
  localparam logic [3:0] S_PROOM  = 4'd3;   // first push: room less header
  localparam logic [3:0] S_PFIT   = 4'd4;   // first push: admit or refuse
  localparam logic [3:0] S_PHDR   = 4'd5;   // write one header byte
  localparam logic [3:0] S_PDATA  = 4'd6;   // write first message byte
  localparam logic [3:0] S_QSTART = 4'd7;   // pop: mid-message or start
  localparam logic [3:0] S_QAVAIL = 4'd8;   // pop: bytes beyond the header
  localparam logic [3:0] S_QRD    = 4'd9;   // pop: issue header byte read
  localparam logic [3:0] S_QHCAP  = 4'd10;  // pop: capture header byte
  localparam logic [3:0] S_QCMP   = 4'd11;  // pop: header against stored count
  localparam logic [3:0] S_QDCAP  = 4'd12;  // pop: capture message byte
  localparam logic [3:0] S_EMIT   = 4'd13;  // hand result to output register

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (idx == AW'(BUFFER_BYTES - 1)) ? '0 : idx + 1'b1;
  endfunction

  // control state
  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     ctail_q, ctail_d;       // tail seen by readers
  logic [AW-1:0]     wtail_q, wtail_d;       // tail of the message being written
  logic [LEN_W-1:0]  push_rem_q, push_rem_d;
  logic              push_rej_q, push_rej_d;
  logic [AW-1:0]     pop_rem_q, pop_rem_d;
  logic [AW-1:0]     pop_len_q, pop_len_d;
  logic              out_valid_q, out_valid_d;

  // working and payload registers
  logic [BYTE_W-1:0] data_q, data_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [AW-1:0]     used_q, used_d;
  logic [DW-1:0]     t_q, t_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     rp_q, rp_d;             // header read pointer
  logic [BYTE_W-1:0] res_data_q, res_data_d;
  logic              res_last_q, res_last_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  status_e           res_status_q, res_status_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  status_e           out_status_q, out_status_d;

  // shared subtractor
  logic [DW-1:0]     alu_a, alu_b, alu_diff;
  logic              alu_neg;
  logic [AW-1:0]     alu_ring;

  // byte store ports
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  // derived terms
  logic              hdr_last;
  logic [BYTE_W-1:0] hdr_byte;
  logic              len_wide;
  logic [AW-1:0]     hdr_low;
  logic              hdr_wide;

  // finishing step of the current item
  logic              fin;
  logic [BYTE_W-1:0] fin_data;
  logic              fin_last;
  logic [LEN_W-1:0]  fin_len;
  status_e           fin_status;

  lpmr_alu #(
    .DW           (DW),
    .AW           (AW),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_lpmr_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .neg_o  (alu_neg),
    .ring_o (alu_ring)
  );

  lpmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_lpmr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign hdr_last = (cnt_q == CW'(HEADER_BYTES - 1));
  // little-endian header: byte cnt of the pushed length
  assign hdr_byte = BYTE_W'(32'(len_q) >> {cnt_q, 3'b000});
  // a length that does not fit a short header is refused
  assign len_wide = ((32'(len_q) >> HDR_W) != 32'd0);
  assign hdr_low  = AW'(hdr_q);
  // any header bit at or above the index width exceeds every stored count
  assign hdr_wide = ((hdr_q >> AW) != '0);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    ctail_d      = ctail_q;
    wtail_d      = wtail_q;
    push_rem_d   = push_rem_q;
    push_rej_d   = push_rej_q;
    pop_rem_d    = pop_rem_q;
    pop_len_d    = pop_len_q;
    out_valid_d  = out_valid_q;
    data_d       = data_q;
    len_d        = len_q;
    used_d       = used_q;
    t_d          = t_q;
    hdr_d        = hdr_q;
    cnt_d        = cnt_q;
    rp_d         = rp_q;
    res_data_d   = res_data_q;
    res_last_d   = res_last_q;
    res_len_d    = res_len_q;
    res_status_d = res_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;

    alu_a     = '0;
    alu_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = wtail_q;
    mem_wdata = data_q;
    mem_re    = 1'b0;
    mem_raddr = head_q;

    fin        = 1'b0;
    fin_data   = '0;
    fin_last   = 1'b0;
    fin_len    = '0;
    fin_status = ST_OK;

    // the waiting word leaves when the far side takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          data_d = data_byte_i;
          len_d  = message_length_i;
          if (operation_i == OP_POP) begin
            state_d = S_QSTART;
          end else if (first_byte_i) begin
            state_d = S_PUSED;
          end else begin
            state_d = S_PBYTE;
          end
        end
      end

      S_PBYTE: begin
        if (push_rem_q == '0) begin
          // stray byte, no message open
          fin        = 1'b1;
          fin_status = ST_NO_SPACE;
        end else begin
          push_rem_d = push_rem_q - 1'b1;
          if (push_rej_q) begin
            push_rej_d = (push_rem_q != LEN_W'(1));
            fin        = 1'b1;
            fin_status = ST_NO_SPACE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wtail_q;
            mem_wdata = data_q;
            wtail_d   = ring_next(wtail_q);
            if (push_rem_q == LEN_W'(1)) begin
              ctail_d = ring_next(wtail_q);
            end
            fin = 1'b1;
          end
        end
      end

      S_PUSED: begin
        // an unfinished message is abandoned
        alu_a   = DW'(ctail_q);
        alu_b   = DW'(head_q);
        used_d  = alu_ring;
        wtail_d = ctail_q;
        state_d = S_PROOM;
      end

      S_PROOM: begin
        alu_a   = DW'(ROOM_K);
        alu_b   = DW'(used_q);
        t_d     = alu_diff;
        state_d = S_PFIT;
      end

      S_PFIT: begin
        alu_a = t_q;
        alu_b = DW'(len_q);
        if (alu_neg || len_wide) begin
          push_rem_d = (len_q != '0) ? len_q - 1'b1 : '0;
          push_rej_d = (len_q > LEN_W'(1));
          fin        = 1'b1;
          fin_status = ST_NO_SPACE;
        end else begin
          push_rej_d = 1'b0;
          cnt_d      = '0;
          state_d    = S_PHDR;
        end
      end

      S_PHDR: begin
        mem_we    = 1'b1;
        mem_waddr = wtail_q;
        mem_wdata = hdr_byte;
        wtail_d   = ring_next(wtail_q);
        cnt_d     = cnt_q + 1'b1;
        if (hdr_last) begin
          if (len_q != '0) begin
            state_d = S_PDATA;
          end else begin
            // zero-length message is complete with its header
            push_rem_d = '0;
            ctail_d    = ring_next(wtail_q);
            fin        = 1'b1;
          end
        end
      end

      S_PDATA: begin
        mem_we     = 1'b1;
        mem_waddr  = wtail_q;
        mem_wdata  = data_q;
        wtail_d    = ring_next(wtail_q);
        push_rem_d = len_q - 1'b1;
        if (len_q == LEN_W'(1)) begin
          ctail_d = ring_next(wtail_q);
        end
        fin = 1'b1;
      end

      S_QSTART: begin
        if (pop_rem_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
          state_d   = S_QDCAP;
        end else if (head_q == ctail_q) begin
          fin        = 1'b1;
          fin_status = ST_EMPTY;
        end else begin
          alu_a   = DW'(ctail_q);
          alu_b   = DW'(head_q);
          used_d  = alu_ring;
          state_d = S_QAVAIL;
        end
      end

      S_QAVAIL: begin
        alu_a = DW'(used_q);
        alu_b = DW'(HEADER_BYTES);
        if (alu_neg) begin
          // not even a whole header stored
          fin        = 1'b1;
          fin_status = ST_CORRUPT;
        end else begin
          t_d     = alu_diff;
          rp_d    = head_q;
          cnt_d   = '0;
          state_d = S_QRD;
        end
      end

      S_QRD: begin
        mem_re    = 1'b1;
        mem_raddr = rp_q;
        state_d   = S_QHCAP;
      end

      S_QHCAP: begin
        hdr_d[{cnt_q, 3'b000} +: BYTE_W] = mem_rdata;
        rp_d  = ring_next(rp_q);
        cnt_d = cnt_q + 1'b1;
        state_d = hdr_last ? S_QCMP : S_QRD;
      end

      S_QCMP: begin
        alu_a = t_q;
        alu_b = DW'(hdr_low);
        if (alu_neg || hdr_wide) begin
          fin        = 1'b1;
          fin_status = ST_CORRUPT;
        end else begin
          head_d    = rp_q;
          pop_len_d = hdr_low;
          if (hdr_low == '0) begin
            fin      = 1'b1;
            fin_last = 1'b1;
          end else begin
            pop_rem_d = hdr_low;
            mem_re    = 1'b1;
            mem_raddr = rp_q;
            state_d   = S_QDCAP;
          end
        end
      end

      S_QDCAP: begin
        head_d    = ring_next(head_q);
        pop_rem_d = pop_rem_q - 1'b1;
        fin       = 1'b1;
        fin_data  = mem_rdata;
        fin_last  = (pop_rem_q == AW'(1));
        fin_len   = LEN_W'(XW'(pop_len_q));
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_last_d   = res_last_q;
          out_len_d    = res_len_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      res_data_d   = fin_data;
      res_last_d   = fin_last;
      res_len_d    = fin_len;
      res_status_d = fin_status;
      state_d      = S_EMIT;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      ctail_q     <= '0;
      wtail_q     <= '0;
      push_rem_q  <= '0;
      push_rej_q  <= 1'b0;
      pop_rem_q   <= '0;
      pop_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      ctail_q     <= ctail_d;
      wtail_q     <= wtail_d;
      push_rem_q  <= push_rem_d;
      push_rej_q  <= push_rej_d;
      pop_rem_q   <= pop_rem_d;
      pop_len_q   <= pop_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, always written before use
  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    len_q        <= len_d;
    used_q       <= used_d;
    t_q          <= t_d;
    hdr_q        <= hdr_d;
    cnt_q        <= cnt_d;
    rp_q         <= rp_d;
    res_data_q   <= res_data_d;
    res_last_q   <= res_last_d;
    res_len_q    <= res_len_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
  end

  // one word in flight at a time; the output register frees the far side
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign last_byte_o  = out_last_q;
  assign length_out_o = out_len_q;
  assign status_o     = out_status_q;

endmodule

>>> design/lpmr_ram.sv
// Generic single-write, single-read RAM with registered read data
module lpmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lpmr_alu.sv
// Shared subtractor: difference, sign and ring-wrapped distance
module lpmr_alu #(
  parameter int unsigned DW           = 14,
  parameter int unsigned AW           = 12,
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic [DW-1:0] diff_o,
  output logic          neg_o,
  output logic [AW-1:0] ring_o
);

  logic [DW-1:0] wrapped;

  assign diff_o  = a_i - b_i;
  assign neg_o   = diff_o[DW-1];
  // negative distance folds back by one ring length
  assign wrapped = diff_o + DW'(BUFFER_BYTES);
  assign ring_o  = neg_o ? wrapped[AW-1:0] : diff_o[AW-1:0];

endmodule

>>> design/lpmr_checker.sv
// Port-level checks for the message ring, bound to the top level
`include "length_prefixed_message_ring_assert.svh"

module lpmr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          operation_i,
  input logic [lpmr_pkg::BYTE_W-1:0]   data_byte_i,
  input logic                          first_byte_i,
  input logic [lpmr_pkg::LEN_W-1:0]    message_length_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lpmr_pkg::BYTE_W-1:0]   data_out_o,
  input logic                          last_byte_o,
  input logic [lpmr_pkg::LEN_W-1:0]    length_out_o,
  input logic [lpmr_pkg::STATUS_W-1:0] status_o
);

  import lpmr_pkg::*;

  // an accepted word keeps the block busy for at least the next cycle
  `LPMR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only appears at the end of a busy period
  `LPMR_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // failed operations carry no byte, no end mark and no length
  `LPMR_ASSERT_NOW(a_error_fields_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, data_out_o == '0 && !last_byte_o && length_out_o == '0)

  // a stalled result word holds
  `LPMR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(data_out_o) && $stable(status_o) && $stable(length_out_o))

endmodule

bind length_prefixed_message_ring lpmr_checker u_lpmr_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the length-prefixed message ring: queued words in, predicted results out
module tb_top;
  import lpmr_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int unsigned RING_BYTES  = DEF_BUFFER_BYTES;
  localparam int unsigned SPARE_SLOTS = DEF_RESERVED_SLOTS;
  localparam int unsigned HDR_BYTES   = DEF_HEADER_BYTES;
  // Longest message that can ever be admitted: an empty ring less spare slot and header
  localparam int unsigned MAX_LEN     = RING_BYTES - SPARE_SLOTS - HDR_BYTES;
  // Watchdog limit: the long output hold plus the slowest header read, many times over
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Settling time once nothing is due: longest pop latency with margin
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_PRINTS  = 30;

  typedef struct {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic [LEN_W-1:0]  len;
  } ring_word_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  len;
    status_e           status;
  } ring_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Input channel, driven by the word driver
  logic              in_valid = 1'b0;
  logic              in_stall;
  op_e               in_op    = OP_PUSH;
  logic [BYTE_W-1:0] in_data  = '0;
  logic              in_first = 1'b0;
  logic [LEN_W-1:0]  in_len   = '0;

  // Result channel, stall driven by the receiver process
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_data;
  logic                out_last;
  logic [LEN_W-1:0]    out_len;
  logic [STATUS_W-1:0] out_status;

  length_prefixed_message_ring u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (in_op),
    .data_byte_i      (in_data),
    .first_byte_i     (in_first),
    .message_length_i (in_len),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .data_out_o       (out_data),
    .last_byte_o      (out_last),
    .length_out_o     (out_len),
    .status_o         (out_status)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  ring_word_t   queued_words [$];   // words waiting for the driver
  ring_result_t due_results  [$];   // predictions for accepted words, oldest first
  ring_word_t   offered;            // word currently on the input port
  ring_result_t due;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_at        = 0;  // input word count that starts the long output hold
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  int unsigned words_queued = 0;
  int unsigned words_in     = 0;
  int unsigned results_out  = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned status_seen [4] = '{default: 0};

  // ---------------------------------------------------------------------------
  // Ring predictor: its own copy of store, pointers and message counters
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  int unsigned rd_ptr     = 0;   // oldest unread byte
  int unsigned commit_ptr = 0;   // end of the last complete message
  int unsigned wr_ptr     = 0;   // write position of the open message
  int unsigned push_left  = 0;   // bytes still owed by the open message
  bit          push_drop  = 1'b0;
  int unsigned pop_left   = 0;   // bytes left of the message being read
  int unsigned pop_len    = 0;

  function automatic int unsigned ring_fill();
    return (commit_ptr + RING_BYTES - rd_ptr) % RING_BYTES;
  endfunction

  function automatic void store_byte(input logic [BYTE_W-1:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % RING_BYTES;
  endfunction

  function automatic ring_result_t predict_ring_word(input ring_word_t w);
    ring_result_t r;
    longint       room;
    int unsigned  fill;
    int unsigned  hdr_len;
    int unsigned  idx;
    r = '{data: '0, last: 1'b0, len: '0, status: ST_OK};
    if (w.op == OP_PUSH) begin
      if (w.first) begin
        // a new message always abandons whatever was open
        wr_ptr = commit_ptr;
        room = longint'(RING_BYTES) - longint'(ring_fill()) - longint'(SPARE_SLOTS);
        if (room < longint'(w.len) + longint'(HDR_BYTES) ||
            (longint'(w.len) >> (8 * HDR_BYTES)) != 0) begin
          push_left = (w.len != 0) ? w.len - 1 : 0;
          push_drop = (push_left != 0);
          r.status = ST_NO_SPACE;
          return r;
        end
        push_drop = 1'b0;
        for (int unsigned i = 0; i < HDR_BYTES; i++)
          store_byte(BYTE_W'(w.len >> (8 * i)));
        if (w.len != 0) begin
          store_byte(w.data);
          push_left = w.len - 1;
        end else begin
          push_left = 0;
        end
        if (push_left == 0)
          commit_ptr = wr_ptr;
        return r;
      end
      if (push_left == 0) begin
        // stray byte, no open message
        r.status = ST_NO_SPACE;
        return r;
      end
      push_left--;
      if (push_drop) begin
        if (push_left == 0)
          push_drop = 1'b0;
        r.status = ST_NO_SPACE;
        return r;
      end
      store_byte(w.data);
      if (push_left == 0)
        commit_ptr = wr_ptr;
      return r;
    end

    // pop
    if (pop_left == 0) begin
      if (rd_ptr == commit_ptr) begin
        r.status = ST_EMPTY;
        return r;
      end
      fill = ring_fill();
      if (fill < HDR_BYTES) begin
        r.status = ST_CORRUPT;
        return r;
      end
      hdr_len = 0;
      idx = rd_ptr;
      for (int unsigned i = 0; i < HDR_BYTES; i++) begin
        hdr_len |= int'(ring_mem[idx]) << (8 * i);
        idx = (idx + 1) % RING_BYTES;
      end
      if (hdr_len > fill - HDR_BYTES) begin
        r.status = ST_CORRUPT;
        return r;
      end
      rd_ptr  = idx;
      pop_len = hdr_len;
      if (hdr_len == 0) begin
        // zero-length message: a single result that ends it
        r.last = 1'b1;
        return r;
      end
      pop_left = hdr_len;
    end
    r.data = ring_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % RING_BYTES;
    pop_left--;
    r.last = (pop_left == 0);
    r.len  = LEN_W'(pop_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_ring_word(offered));
        words_in++;
      end
      // payload only moves once the current word has gone
      if (!in_valid || !in_stall) begin
        if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = queued_words.pop_front();
          in_valid <= 1'b1;
          in_op    <= offered.op;
          in_data  <= offered.data;
          in_first <= offered.first;
          in_len   <= offered.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold, counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && hold_at != 0 && words_in >= hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: field-by-field check against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $time, results_out, what,
               got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      results_out++;
      status_seen[out_status]++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(out_status), 0);
      end else begin
        due = due_results.pop_front();
        if (out_data !== due.data)
          report_mismatch("data_out", 32'(out_data), 32'(due.data));
        if (out_last !== due.last)
          report_mismatch("last_byte", 32'(out_last), 32'(due.last));
        if (out_len !== due.len)
          report_mismatch("length_out", 32'(out_len), 32'(due.len));
        if (out_status !== due.status)
          report_mismatch("status", 32'(out_status), 32'(due.status));
      end
    end
  end

  // Watchdog: nothing accepted on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: %0d cycles without a word, %0d results still due",
                   idle_cycles, due_results.size());
          $display("length_prefixed_message_ring test failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_push(input logic first, input int unsigned len,
                            input int unsigned data);
    ring_word_t w;
    w.op    = OP_PUSH;
    w.data  = BYTE_W'(data);
    w.first = first;
    w.len   = LEN_W'(len);
    queued_words.push_back(w);
    words_queued++;
  endtask

  // pop words carry random don't-care fields
  task automatic queue_pop(input int unsigned n);
    ring_word_t w;
    for (int unsigned k = 0; k < n; k++) begin
      w.op    = OP_POP;
      w.data  = BYTE_W'($urandom_range(255));
      w.first = 1'($urandom_range(1));
      w.len   = LEN_W'($urandom_range(MAX_LEN));
      queued_words.push_back(w);
      words_queued++;
    end
  endtask

  // well-formed message with pops sprinkled in while it is still open
  task automatic queue_message(input int unsigned len, input int unsigned pop_mix);
    queue_push(1'b1, len, $urandom_range(255));
    for (int unsigned k = 1; k < len; k++) begin
      if ($urandom_range(99) < pop_mix)
        queue_pop(1);
      queue_push(1'b0, $urandom_range(MAX_LEN), $urandom_range(255));
    end
  endtask

  // sender pause: let everything queued go in and every result come back
  task automatic drain();
    while (queued_words.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned cnt;
    stop_at = words_queued + n;
    while (words_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // mostly short messages, now and then a longer one
        pick = $urandom_range(99);
        if (pick < 80)
          len = $urandom_range(8);
        else if (pick < 97)
          len = $urandom_range(32, 9);
        else
          len = $urandom_range(200, 33);
        queue_message(len, 15);
        queue_pop(len + $urandom_range(2));
      end else if (pick < 80) begin
        // broken message: any length, cut short, later abandoned
        queue_push(1'b1, $urandom_range(MAX_LEN), $urandom_range(255));
        cnt = $urandom_range(3);
        for (int unsigned k = 0; k < cnt; k++)
          queue_push(1'b0, $urandom_range(MAX_LEN), $urandom_range(255));
      end else if (pick < 88) begin
        cnt = $urandom_range(3, 1);
        for (int unsigned k = 0; k < cnt; k++)
          queue_push(1'b0, $urandom_range(MAX_LEN), $urandom_range(255));
      end else begin
        queue_pop($urandom_range(4, 1));
      end
    end
  endtask

  initial begin
    int unsigned fit_len;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty ring, stray byte, zero-length message, abandoned and refused
    // messages, byte extremes
    queue_pop(1);
    queue_push(1'b0, 0, 'hC3);
    queue_push(1'b1, 0, 'hFF);           // zero-length, byte ignored
    queue_pop(2);
    queue_push(1'b1, 3, 'h00);
    queue_push(1'b0, 0, 'hFF);
    queue_push(1'b0, MAX_LEN, 'hA5);
    queue_push(1'b1, MAX_LEN, 'h5A);     // too big with bytes stored
    queue_push(1'b0, 0, 'h12);           // dropped
    queue_push(1'b1, 2, 'h5A);           // opened, then abandoned
    queue_push(1'b1, 1, 'h81);
    queue_pop(5);
    queue_push(1'b1, 1, 'h7E);
    queue_push(1'b0, 0, 'h3C);           // stray after commit
    queue_pop(2);
    drain();

    // Room boundary: one byte over refused, exact fit admitted and then abandoned
    queue_message(6, 0);
    drain();
    fit_len = MAX_LEN - ring_fill();
    queue_push(1'b1, fit_len + 1, $urandom_range(255));
    queue_push(1'b0, 0, $urandom_range(255));
    queue_push(1'b1, fit_len, $urandom_range(255));
    queue_push(1'b0, 0, $urandom_range(255));
    queue_pop(1);                        // open message stays out of sight
    queue_push(1'b1, 0, $urandom_range(255));
    queue_pop(8);
    drain();

    // Random phases with different idling; each ends with a sender pause
    random_traffic(350);
    drain();

    send_idle_pct = 59;
    random_traffic(350);
    drain();

    // receiver stalls, plus one long hold while the sender keeps going
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    hold_at        = words_in + 40;
    random_traffic(350);
    drain();

    send_idle_pct  = 25;
    recv_stall_pct = 25;
    random_traffic(350);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", 0, due_results.size());

    $display("Run covered %0d words in and %0d results out: %0d ok, %0d empty, %0d refused",
             words_in, results_out, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_NO_SPACE]);
    $display("including room boundary checks, abandoned messages and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("length_prefixed_message_ring test passed");
    end else begin
      $display("length_prefixed_message_ring test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/lpmr_pkg.sv
design/lpmr_ram.sv
design/lpmr_alu.sv
design/length_prefixed_message_ring.sv
design/lpmr_checker.sv
sim/tb_top.sv
